[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/cnvs_pkg.sv]
`timescale 1ns / 1ps

package cnvs_pkg;

  // field widths of the channel beats
  localparam int EW        = 16;
  localparam int DIM_REG_W = 7;
  localparam int IDX_W     = 10;
  localparam int DIST_W    = 40;
  localparam int STAT_W    = 2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_DIMENSION = 1'b0;
  localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd64;

  // saturation ceiling of the distance
  localparam logic [DIST_W-1:0] DIST_MAX = 40'hFF_FFFF_FFFF;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_CAP     = 2'd2;

  typedef struct packed {
    logic signed [EW-1:0] element;
    logic                 last_of_set;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  medoid_index;
    logic [DIST_W-1:0] min_distance;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  // per-coordinate tag that follows the store read into the distance pipe
  typedef struct packed {
    logic valid;
    logic last_coord;
  } dist_tap_t;

endpackage

[hdl/cnvs_if.sv]
`timescale 1ns / 1ps

// coordinate stream
interface cnvs_in_if;
  logic               valid;
  logic               ready;
  cnvs_pkg::in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

// result stream
interface cnvs_out_if;
  logic                valid;
  logic                ready;
  cnvs_pkg::out_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

[hdl/cnvs_apb.sv]
`timescale 1ns / 1ps

module cnvs_apb (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cnvs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cnvs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cnvs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [cnvs_pkg::DIM_REG_W-1:0]      dimension
);

  localparam int AW = cnvs_pkg::CFG_ADDR_W;
  localparam int DW = cnvs_pkg::CFG_DATA_W;
  localparam int RW = cnvs_pkg::DIM_REG_W;

  logic [RW-1:0] dim_r;
  logic          sel_dim;
  logic          wr_en;

  // word decode, byte offset ignored
  assign sel_dim = (paddr[AW-1:2] == cnvs_pkg::REG_DIMENSION);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= cnvs_pkg::DIM_RESET;
    end else if (wr_en && sel_dim) begin
      dim_r <= pwdata[RW-1:0];
    end
  end

  // read back
  assign prdata    = sel_dim ? DW'(dim_r) : '0;
  assign pready    = 1'b1;
  assign dimension = dim_r;

endmodule

[hdl/cnvs_div.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle, truncates toward zero
module cnvs_div #(
  parameter int SW = 26,
  parameter int VW = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [SW-1:0]            dividend,
  input  logic [VW-1:0]                   divisor,
  output logic                            busy,
  output logic                            done,
  output logic signed [cnvs_pkg::EW-1:0]  quotient
);

  localparam int CNT_W = $clog2(SW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SW-1:0]     mag_r;
  logic [VW-1:0]     rem_r;
  logic [VW-1:0]     den_r;
  logic              neg_r;
  logic [VW:0]       rem_sh;
  logic              q_bit;
  logic [SW-1:0]     q_signed;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_r, mag_r[SW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in behind the dividend magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
      neg_r <= dividend[SW-1];
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      mag_r <= {mag_r[SW-2:0], q_bit};
      rem_r <= q_bit ? VW'(rem_sh - {1'b0, den_r}) : VW'(rem_sh);
    end
  end

  assign q_signed = neg_r ? SW'(-mag_r) : mag_r;
  assign quotient = q_signed[cnvs_pkg::EW-1:0];
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

[hdl/cnvs_dist.sv]
`timescale 1ns / 1ps

// squared distance per vector and running minimum, first on ties
module cnvs_dist #(
  parameter int VIW = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cnvs_pkg::dist_tap_t                  tap,
  input  logic [VIW-1:0]                       tap_vec,
  input  logic signed [cnvs_pkg::EW-1:0]       elem,
  input  logic signed [cnvs_pkg::EW-1:0]       cent,
  output logic                                 busy,
  output logic [VIW-1:0]                       best_idx,
  output logic [cnvs_pkg::DIST_W-1:0]          best_dist
);

  localparam int EW = cnvs_pkg::EW;
  localparam int DW = cnvs_pkg::DIST_W;
  localparam int MW = EW + 1;
  localparam int QW = 2 * MW;

  cnvs_pkg::dist_tap_t s1_tap_r, s2_tap_r;
  logic [VIW-1:0]      s1_vec_r, s2_vec_r, vd_idx_r, best_idx_r;
  logic signed [MW-1:0] diff_r;
  logic [MW-1:0]       mag;
  logic [QW-1:0]       sq_r;
  logic [DW-1:0]       acc_r;
  logic [DW:0]         acc_sum;
  logic [DW-1:0]       acc_sat;
  logic                vd_v_r;
  logic [DW-1:0]       vd_dist_r, best_dist_r;

  assign mag     = diff_r[MW-1] ? MW'(-diff_r) : MW'(diff_r);
  assign acc_sum = (DW + 1)'(acc_r) + (DW + 1)'(sq_r);
  assign acc_sat = (acc_sum >= (DW + 1)'(cnvs_pkg::DIST_MAX)) ? cnvs_pkg::DIST_MAX
                                                              : acc_sum[DW-1:0];

  // stage valids and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tap_r <= '0;
      s2_tap_r <= '0;
      vd_v_r   <= 1'b0;
      acc_r    <= '0;
    end else begin
      s1_tap_r <= tap;
      s2_tap_r <= s1_tap_r;
      vd_v_r   <= s2_tap_r.valid && s2_tap_r.last_coord;
      if (s2_tap_r.valid) begin
        acc_r <= s2_tap_r.last_coord ? '0 : acc_sat;
      end
    end
  end

  // difference, square, finished vector, minimum
  always_ff @(posedge clk) begin
    diff_r   <= MW'(elem) - MW'(cent);
    s1_vec_r <= tap_vec;
    sq_r     <= mag * mag;
    s2_vec_r <= s1_vec_r;
    if (s2_tap_r.valid && s2_tap_r.last_coord) begin
      vd_dist_r <= acc_sat;
      vd_idx_r  <= s2_vec_r;
    end
    if (vd_v_r && (vd_idx_r == '0 || vd_dist_r < best_dist_r)) begin
      best_dist_r <= vd_dist_r;
      best_idx_r  <= vd_idx_r;
    end
  end

  assign busy      = s1_tap_r.valid || s2_tap_r.valid || vd_v_r;
  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;

endmodule

[hdl/centroid_nearest_vector_select.sv]
`timescale 1ns / 1ps
// Medoid select over a streamed vector set.
// in_ch carries one signed coordinate a beat, vector after vector, with
// last_of_set on the final coordinate of the set; one beat is taken each
// cycle while loading. out_ch carries one result per set: index of the
// stored vector nearest the centroid (first on ties), its squared distance
// and a status (ok, set not whole vectors, capacity exceeded).
// The dimension register sits at byte address 0 of the apb port.
// After the last beat: a settle state, then per coordinate a sum read and a
// pass through the serial divider (SW = 16 + log2(MAX_VECTORS)), then
// store reads over every coordinate of every vector, a pipeline drain and
// a sweep that zeroes the sum memory, then the result is registered. A
// flagged set skips the arithmetic: settle, sweep, then the result. The
// store read port sets the distance rate.
// Reset starts with the same sweep; in_ch.ready stays low
// until it ends. The result sits in an output register, so a new set loads
// while out_ch is stalled; a finished set then waits until the register
// frees up.
module centroid_nearest_vector_select #(
  parameter int MAX_VECTORS = 1024,
  parameter int MAX_DIM     = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cnvs_in_if.sink                             in_ch,
  cnvs_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cnvs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cnvs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cnvs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  `include "assert_macros.svh"

  localparam int EW     = cnvs_pkg::EW;
  localparam int RW     = cnvs_pkg::DIM_REG_W;
  localparam int IW     = cnvs_pkg::IDX_W;
  localparam int CW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int DXW    = (DIM_W > RW) ? DIM_W : RW;
  localparam int VW     = $clog2(MAX_VECTORS + 1);
  localparam int VIW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int SW     = EW + $clog2(MAX_VECTORS);
  localparam int SDEPTH = MAX_VECTORS * (2 ** CW);

  // sequencer states
  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_LOAD      = 4'd1;
  localparam logic [3:0] ST_SETTLE    = 4'd2;
  localparam logic [3:0] ST_CENT_RD   = 4'd3;
  localparam logic [3:0] ST_CENT_GO   = 4'd4;
  localparam logic [3:0] ST_CENT_WAIT = 4'd5;
  localparam logic [3:0] ST_DIST      = 4'd6;
  localparam logic [3:0] ST_DRAIN     = 4'd7;
  localparam logic [3:0] ST_FIN       = 4'd8;

  // memories
  logic signed [EW-1:0] store_mem [SDEPTH];
  logic signed [SW-1:0] sums_mem  [MAX_DIM];
  logic signed [EW-1:0] cent_mem  [MAX_DIM];

  logic [RW-1:0]        dimension;
  logic [DXW-1:0]       dim_ext;
  logic [DIM_W-1:0]     dim_use;
  logic [CW-1:0]        dim_last;

  logic [3:0]           state_r, state_nxt;
  logic [CW-1:0]        coord_r, coord_nxt;
  logic [VW-1:0]        vec_r, vec_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 res_pend_r, res_pend_nxt;
  logic [CW-1:0]        clr_c_r, clr_c_nxt;
  logic [CW-1:0]        cent_c_r, cent_c_nxt;
  logic [VIW-1:0]       dv_r, dv_nxt;
  logic [CW-1:0]        dc_r, dc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cnvs_pkg::out_beat_t  out_beat_r, out_beat_nxt;

  logic                 in_acc;
  logic                 vec_full;
  logic [CW-1:0]        cc_eff;
  logic                 cc_wrap;
  logic [VIW-1:0]       vec_last;

  // sum read-modify-write pipe
  logic                 p_v_r, lw_v_r;
  logic [CW-1:0]        p_addr_r, lw_addr_r;
  logic signed [EW-1:0] p_e_r;
  logic signed [SW-1:0] lw_val_r, sum_rd_r, sum_fwd, sum_new;
  logic                 sum_we;
  logic [CW-1:0]        sum_wa, sum_ra;
  logic signed [SW-1:0] sum_wd;

  // divider and distance pipe
  logic                 div_start, div_busy, div_done;
  logic signed [EW-1:0] div_q;
  cnvs_pkg::dist_tap_t  tap_r;
  logic [VIW-1:0]       tap_vec_r;
  logic signed [EW-1:0] st_q_r, ce_q_r;
  logic                 dist_busy;
  logic [VIW-1:0]       best_idx;
  logic [cnvs_pkg::DIST_W-1:0] best_dist;

  // result beat terms for the checks
  logic                 out_is_err;
  logic                 out_fields_zero;

  cnvs_apb u_apb (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .dimension (dimension)
  );

  // dimension in use, clamped to 1..MAX_DIM
  assign dim_ext = DXW'(dimension);
  always_comb begin
    if (dim_ext == '0) begin
      dim_use = DIM_W'(1);
    end else if (dim_ext > DXW'(MAX_DIM)) begin
      dim_use = DIM_W'(MAX_DIM);
    end else begin
      dim_use = DIM_W'(dim_ext);
    end
  end
  assign dim_last = CW'(dim_use - DIM_W'(1));

  // load bookkeeping
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign vec_full = (vec_r == VW'(MAX_VECTORS));
  assign cc_eff   = (DIM_W'(coord_r) < dim_use) ? coord_r : dim_last;
  assign cc_wrap  = (cc_eff == dim_last);
  assign vec_last = VIW'(vec_r - VW'(1));

  // sum forwarding: the previous beat's write lands at the same edge as this read
  assign sum_fwd = (lw_v_r && lw_addr_r == p_addr_r) ? lw_val_r : sum_rd_r;
  assign sum_new = sum_fwd + SW'(p_e_r);

  assign sum_we = p_v_r || (state_r == ST_CLEAR);
  assign sum_wa = p_v_r ? p_addr_r : clr_c_r;
  assign sum_wd = p_v_r ? sum_new : '0;
  assign sum_ra = (state_r == ST_LOAD) ? cc_eff : cent_c_r;

  assign div_start = (state_r == ST_CENT_GO);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    coord_nxt     = coord_r;
    vec_nxt       = vec_r;
    ovf_nxt       = ovf_r;
    status_nxt    = status_r;
    res_pend_nxt  = res_pend_r;
    clr_c_nxt     = clr_c_r;
    cent_c_nxt    = cent_c_r;
    dv_nxt        = dv_r;
    dc_nxt        = dc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_beat_nxt  = out_beat_r;
    case (state_r)
      ST_CLEAR: begin
        clr_c_nxt = clr_c_r + 1'b1;
        if (clr_c_r == CW'(MAX_DIM - 1)) begin
          clr_c_nxt = '0;
          state_nxt = res_pend_r ? ST_FIN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_acc) begin
          if (vec_full) begin
            ovf_nxt = 1'b1;
          end else if (cc_wrap) begin
            coord_nxt = '0;
            vec_nxt   = vec_r + 1'b1;
          end else begin
            coord_nxt = cc_eff + 1'b1;
          end
          if (in_ch.beat.last_of_set) begin
            if (ovf_nxt) begin
              status_nxt = cnvs_pkg::STATUS_CAP;
            end else if (coord_nxt != '0 || vec_nxt == '0) begin
              status_nxt = cnvs_pkg::STATUS_PARTIAL;
            end else begin
              status_nxt = cnvs_pkg::STATUS_OK;
            end
            state_nxt = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        if (status_r == cnvs_pkg::STATUS_OK) begin
          cent_c_nxt = '0;
          state_nxt  = ST_CENT_RD;
        end else begin
          res_pend_nxt = 1'b1;
          state_nxt    = ST_CLEAR;
        end
      end
      ST_CENT_RD: begin
        state_nxt = ST_CENT_GO;
      end
      ST_CENT_GO: begin
        state_nxt = ST_CENT_WAIT;
      end
      ST_CENT_WAIT: begin
        if (div_done) begin
          if (cent_c_r == dim_last) begin
            cent_c_nxt = '0;
            dv_nxt     = '0;
            dc_nxt     = '0;
            state_nxt  = ST_DIST;
          end else begin
            cent_c_nxt = cent_c_r + 1'b1;
            state_nxt  = ST_CENT_RD;
          end
        end
      end
      ST_DIST: begin
        if (dc_r == dim_last) begin
          dc_nxt = '0;
          if (dv_r == vec_last) begin
            dv_nxt    = '0;
            state_nxt = ST_DRAIN;
          end else begin
            dv_nxt = dv_r + 1'b1;
          end
        end else begin
          dc_nxt = dc_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!tap_r.valid && !dist_busy) begin
          res_pend_nxt = 1'b1;
          state_nxt    = ST_CLEAR;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt.status = status_r;
          if (status_r == cnvs_pkg::STATUS_OK) begin
            out_beat_nxt.medoid_index = IW'(best_idx);
            out_beat_nxt.min_distance = best_dist;
          end else begin
            out_beat_nxt.medoid_index = '0;
            out_beat_nxt.min_distance = '0;
          end
          coord_nxt    = '0;
          vec_nxt      = '0;
          ovf_nxt      = 1'b0;
          res_pend_nxt = 1'b0;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      coord_r     <= '0;
      vec_r       <= '0;
      ovf_r       <= 1'b0;
      status_r    <= cnvs_pkg::STATUS_OK;
      res_pend_r  <= 1'b0;
      clr_c_r     <= '0;
      cent_c_r    <= '0;
      dv_r        <= '0;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
      p_v_r       <= 1'b0;
      lw_v_r      <= 1'b0;
      tap_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      coord_r     <= coord_nxt;
      vec_r       <= vec_nxt;
      ovf_r       <= ovf_nxt;
      status_r    <= status_nxt;
      res_pend_r  <= res_pend_nxt;
      clr_c_r     <= clr_c_nxt;
      cent_c_r    <= cent_c_nxt;
      dv_r        <= dv_nxt;
      dc_r        <= dc_nxt;
      out_valid_r <= out_valid_nxt;
      p_v_r       <= in_acc && !vec_full;
      lw_v_r      <= p_v_r;
      tap_r.valid      <= (state_r == ST_DIST);
      tap_r.last_coord <= (state_r == ST_DIST) && (dc_r == dim_last);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
    p_addr_r   <= cc_eff;
    p_e_r      <= in_ch.beat.element;
    lw_addr_r  <= p_addr_r;
    lw_val_r   <= sum_new;
    tap_vec_r  <= dv_r;
  end

  // vector store: one write per beat taken within capacity, one read per distance step
  always_ff @(posedge clk) begin
    if (in_acc && !vec_full) begin
      store_mem[{VIW'(vec_r), cc_eff}] <= in_ch.beat.element;
    end
    st_q_r <= store_mem[{dv_r, dc_r}];
  end

  // coordinate sums
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sums_mem[sum_wa] <= sum_wd;
    end
    sum_rd_r <= sums_mem[sum_ra];
  end

  // centroid
  always_ff @(posedge clk) begin
    if (state_r == ST_CENT_WAIT && div_done) begin
      cent_mem[cent_c_r] <= div_q;
    end
    ce_q_r <= cent_mem[dc_r];
  end

  cnvs_div #(
    .SW (SW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_rd_r),
    .divisor  (vec_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  cnvs_dist #(
    .VIW (VIW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tap       (tap_r),
    .tap_vec   (tap_vec_r),
    .elem      (st_q_r),
    .cent      (ce_q_r),
    .busy      (dist_busy),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = out_valid_r;
  assign out_ch.beat  = out_beat_r;

  // checks
  assign out_is_err      = out_valid_r && (out_beat_r.status != cnvs_pkg::STATUS_OK);
  assign out_fields_zero = (out_beat_r.medoid_index == '0) &&
                           (out_beat_r.min_distance == '0);

  `ASSERT_IMPLIES(a_sum_settled, clk, rst_n, state_r == ST_CENT_RD, !p_v_r)
  `ASSERT_IMPLIES(a_div_start, clk, rst_n, div_start, !div_busy && vec_r != '0)
  `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_is_err, out_fields_zero)
  `ASSERT_NEXT(a_last_settles, clk, rst_n, in_acc && in_ch.beat.last_of_set, state_r == ST_SETTLE)

endmodule

[sim/centroid_nearest_vector_select_tb.sv]
`timescale 1ns / 1ps

module centroid_nearest_vector_select_tb;

  localparam int MAX_VECTORS  = 1024;
  localparam int MAX_DIM      = 64;
  localparam int SETTLE       = MAX_DIM + 16;
  localparam int IDLE_LIMIT   = 30000;
  localparam int RANDOM_ITEMS = 550;
  localparam int LONG_HOLD    = 600;

  localparam int EW         = cnvs_pkg::EW;
  localparam int DIM_REG_W  = cnvs_pkg::DIM_REG_W;
  localparam int CFG_ADDR_W = cnvs_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = cnvs_pkg::CFG_DATA_W;
  localparam int IDX_W      = cnvs_pkg::IDX_W;
  localparam int DIST_W     = cnvs_pkg::DIST_W;

  localparam logic [CFG_ADDR_W-1:0] DIM_ADDR  = {cnvs_pkg::REG_DIMENSION, 2'b00};
  localparam logic [63:0]           DIST_CEIL = 64'(cnvs_pkg::DIST_MAX);
  localparam logic signed [EW-1:0]  ELEM_MIN  = {1'b1, {(EW - 1){1'b0}}};
  localparam logic signed [EW-1:0]  ELEM_MAX  = {1'b0, {(EW - 1){1'b1}}};

  typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cnvs_in_if  in_if ();
  cnvs_out_if out_if ();

  centroid_nearest_vector_select #(
    .MAX_VECTORS(MAX_VECTORS),
    .MAX_DIM    (MAX_DIM)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk = ~clk;

  // shadow of the block: stored coordinates, sums and counters
  logic signed [EW-1:0]  vec_store [MAX_VECTORS * MAX_DIM];
  longint                coord_sum [MAX_DIM];
  longint                mean [MAX_DIM];
  int unsigned           coord_count;
  int unsigned           vec_count;
  bit                    overflowed;
  logic [DIM_REG_W-1:0]  dim_reg;
  cnvs_pkg::out_beat_t   medoid_q [$];

  int          errors = 0;
  int          idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  int unsigned rx_hold_request = 0;

  function automatic int unsigned active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return 32'(dim_reg);
  endfunction

  function automatic void clear_set();
    foreach (coord_sum[i]) coord_sum[i] = 0;
    coord_count = 0;
    vec_count   = 0;
    overflowed  = 1'b0;
  endfunction

  // store one coordinate; on the last beat of a set work out the medoid
  function automatic void predict_medoid(logic signed [EW-1:0] elem, logic last);
    int unsigned         d;
    int unsigned         cc;
    int unsigned         c;
    int unsigned         v;
    int unsigned         best_v;
    logic [63:0]         best;
    logic [63:0]         acc;
    logic [63:0]         mag;
    longint              diff;
    cnvs_pkg::out_beat_t res;
    d = active_dim();
    if (vec_count >= MAX_VECTORS) begin
      overflowed = 1'b1;
    end else begin
      cc = (coord_count < d) ? coord_count : d - 1;
      vec_store[vec_count * MAX_DIM + cc] = elem;
      coord_sum[cc] += elem;
      if (cc + 1 >= d) begin
        coord_count = 0;
        vec_count++;
      end else begin
        coord_count = cc + 1;
      end
    end
    if (!last) return;
    res    = '0;
    best   = '0;
    best_v = 0;
    if (overflowed) begin
      res.status = cnvs_pkg::STATUS_CAP;
    end else if (coord_count != 0 || vec_count == 0) begin
      res.status = cnvs_pkg::STATUS_PARTIAL;
    end else begin
      // centroid truncates toward zero, distances saturate
      for (c = 0; c < d; c++) mean[c] = coord_sum[c] / longint'(vec_count);
      for (v = 0; v < vec_count; v++) begin
        acc = '0;
        for (c = 0; c < d; c++) begin
          diff = longint'(vec_store[v * MAX_DIM + c]) - mean[c];
          mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
          if (mag >= (64'd1 << 20)) acc = DIST_CEIL;
          else acc += mag * mag;
          if (acc >= DIST_CEIL) begin
            acc = DIST_CEIL;
            break;
          end
        end
        if (v == 0 || acc < best) begin
          best   = acc;
          best_v = v;
        end
      end
      res.status       = cnvs_pkg::STATUS_OK;
      res.medoid_index = best_v[IDX_W-1:0];
      res.min_distance = best[DIST_W-1:0];
    end
    medoid_q.push_back(res);
    clear_set();
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endfunction

  function automatic logic signed [EW-1:0] random_element(logic signed [EW-1:0] centre,
                                                          int unsigned span);
    if (span != 0) begin
      case ($urandom_range(0, 11))
        0: return ELEM_MIN;
        1: return ELEM_MAX;
        default: ;
      endcase
    end
    return centre + EW'($urandom_range(0, span) - span / 2);
  endfunction

  // result checker
  always @(posedge clk) begin
    cnvs_pkg::out_beat_t got;
    cnvs_pkg::out_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.beat;
      if (medoid_q.size() == 0) begin
        flag_mismatch("result beat with nothing pending, status", 0, got.status);
      end else begin
        want = medoid_q.pop_front();
        if (got.medoid_index !== want.medoid_index)
          flag_mismatch("medoid_index", want.medoid_index, got.medoid_index);
        if (got.min_distance !== want.min_distance)
          flag_mismatch("min_distance", want.min_distance, got.min_distance);
        if (got.status !== want.status)
          flag_mismatch("status", want.status, got.status);
      end
    end
  end

  // watchdog on cycles without any beat or register access
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** centroid_nearest_vector_select: FAILED **");
      $finish;
    end
  end

  // result receiver: stall pattern changes mode every so often
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    out_if.ready <= 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          RX_FREE:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 7) != 0);
          default:   out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // register access: setup phase, access phase, then the bus goes idle
  task automatic write_dimension(input logic [DIM_REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIM_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dim_reg = value;
    @(posedge clk);
  endtask

  task automatic read_dimension();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DIM_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(dim_reg)) flag_mismatch("dimension readback", dim_reg, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one coordinate beat, with burst gaps in front
  task automatic send_beat(input logic signed [EW-1:0] elem, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.beat  <= '{element: elem, last_of_set: last};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_medoid(elem, last);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (medoid_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_register_access();
    read_dimension();
    write_dimension(7'd127);
    read_dimension();
    write_dimension(7'd0);
    read_dimension();
    write_dimension(7'd42);
    read_dimension();
  endtask

  // most negative and most positive coordinates in one set
  task automatic test_extremes();
    write_dimension(7'd2);
    send_beat(ELEM_MIN, 1'b0);
    send_beat(ELEM_MAX, 1'b0);
    send_beat(ELEM_MAX, 1'b0);
    send_beat(ELEM_MIN, 1'b0);
    send_beat(16'sd0, 1'b0);
    send_beat(16'sd0, 1'b1);
    wait_drained();
  endtask

  // equal distances pick the first vector; negative means truncate toward zero
  task automatic test_ties_and_rounding();
    write_dimension(7'd1);
    send_beat(16'sd0, 1'b0);
    send_beat(16'sd2, 1'b1);
    send_beat(-16'sd3, 1'b0);
    send_beat(16'sd0, 1'b1);
    wait_drained();
  endtask

  // set not whole vectors, set with no whole vector, then a clean set
  task automatic test_partial_sets();
    write_dimension(7'd3);
    send_beat(16'sd10, 1'b0);
    send_beat(16'sd20, 1'b0);
    send_beat(16'sd30, 1'b0);
    send_beat(16'sd40, 1'b1);
    send_beat(-16'sd7, 1'b1);
    send_beat(16'sd1, 1'b0);
    send_beat(-16'sd1, 1'b0);
    send_beat(16'sd5, 1'b1);
    wait_drained();
  endtask

  // zero dimension behaves as one
  task automatic test_zero_dimension();
    write_dimension(7'd0);
    send_beat(16'sd5, 1'b0);
    send_beat(-16'sd5, 1'b0);
    send_beat(16'sd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_capacity();
    write_dimension(7'd1);
    // full store: ramp of tens, last vector sits exactly on the centroid
    for (int i = 0; i < MAX_VECTORS; i++)
      send_beat((i == MAX_VECTORS - 1) ? EW'(5119) : EW'(10 * (i + 1)), i == MAX_VECTORS - 1);
    wait_drained();
    // one coordinate beyond capacity
    for (int i = 0; i <= MAX_VECTORS; i++)
      send_beat(random_element(16'sd0, 65535), i == MAX_VECTORS);
    wait_drained();
  endtask

  // long receiver hold while sets keep coming, so the input stalls
  task automatic test_backpressure();
    write_dimension(7'd1);
    rx_hold_request = LONG_HOLD;
    steady = 1'b1;
    for (int s = 0; s < 8; s++)
      for (int i = 0; i < 5; i++) send_beat(random_element(16'sd0, 255), i == 4);
    steady = 1'b0;
    wait_drained();
  endtask

  // phases of set dimension, the first four fixed and the rest random, each a handful of mostly well-formed sets
  task automatic test_random_sets();
    int unsigned          sent;
    int unsigned          sets;
    int unsigned          phase;
    int unsigned          d;
    int unsigned          nmax;
    int unsigned          len;
    int unsigned          span;
    logic [DIM_REG_W-1:0] dim_pick;
    logic signed [EW-1:0] centre;
    sent  = 0;
    sets  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS || sets < 40) begin
      case (phase)
        0: dim_pick = 7'd1;
        1: dim_pick = 7'd127;
        2: dim_pick = 7'd0;
        3: dim_pick = 7'd2;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: dim_pick = DIM_REG_W'($urandom_range(1, 8));
            6, 7:             dim_pick = DIM_REG_W'($urandom_range(9, 64));
            8:                dim_pick = DIM_REG_W'($urandom_range(65, 127));
            default:          dim_pick = 7'd0;
          endcase
        end
      endcase
      write_dimension(dim_pick);
      steady = ($urandom_range(0, 3) == 0);
      d = active_dim();
      nmax = 160 / d;
      if (nmax > 12) nmax = 12;
      repeat ($urandom_range(3, 6)) begin
        len = $urandom_range(1, nmax) * d;
        if ($urandom_range(0, 6) == 0) len = $urandom_range(1, len + d);
        centre = EW'($urandom);
        case ($urandom_range(0, 3))
          0:       span = 65535;
          1:       span = 15;
          2:       span = 1023;
          default: span = 0;
        endcase
        for (int i = 0; i < len; i++) send_beat(random_element(centre, span), i == len - 1);
        sent += len;
        sets++;
      end
      steady = 1'b0;
      wait_drained();
      phase++;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_if.valid <= 1'b0;
    in_if.beat  <= '0;
    dim_reg = cnvs_pkg::DIM_RESET;
    clear_set();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_extremes();
    test_ties_and_rounding();
    test_partial_sets();
    test_zero_dimension();
    test_capacity();
    test_backpressure();
    test_random_sets();

    wait_drained();
    if (errors == 0 && medoid_q.size() == 0)
      $display("** centroid_nearest_vector_select: PASSED **");
    else
      $display("** centroid_nearest_vector_select: FAILED **");
    $finish;
  end

endmodule
